/* rtl/xalu_pkg.sv */
`default_nettype none
package xalu_pkg;

   typedef enum logic [3:0] {
      ACT_ADD  = 4'd0,
      ACT_ADC  = 4'd1,
      ACT_SUB  = 4'd2,
      ACT_SBB  = 4'd3,
      ACT_MUL  = 4'd4,
      ACT_IMUL = 4'd5,
      ACT_DIV  = 4'd6,
      ACT_MOD  = 4'd7,
      ACT_AND  = 4'd8,
      ACT_XOR  = 4'd9,
      ACT_OR   = 4'd10,
      ACT_SHL  = 4'd11,
      ACT_SHR  = 4'd12,
      ACT_SAR  = 4'd13,
      ACT_SAL  = 4'd14,
      ACT_NONE = 4'd15
   } action_type;

   typedef enum logic [1:0] {
      SIZE_8  = 2'd0,
      SIZE_16 = 2'd1,
      SIZE_32 = 2'd2,
      SIZE_32X = 2'd3
   } size_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_DIV,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic load_op;
      logic div_init;
      logic div_step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic div_run;
      logic div_last;
      logic out_free;
   } status_type;

   typedef struct packed {
      logic c;
      logic p;
      logic z;
      logic s;
      logic o;
   } flags_type;

   localparam int DivSteps = 64;
   localparam int CountWidth = $clog2(DivSteps);

endpackage
`default_nettype wire

/* rtl/xalu_ctrl.sv */
`default_nettype none
module xalu_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  xalu_pkg::status_type   status,
   output xalu_pkg::cmd_type      cmd
);
   import xalu_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_op = 1'b1;
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (status.div_run) begin
               cmd.div_init = 1'b1;
               state_in = ST_DIV;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

/* rtl/xalu_dp.sv */
`default_nettype none
module xalu_dp (
   input  wire                    clock,
   input  wire                    reset,
   input  xalu_pkg::cmd_type      cmd,
   output xalu_pkg::status_type   status,
   input  wire  [3:0]             req_action,
   input  wire  [1:0]             req_size_sel,
   input  wire  [63:0]            req_src_operand,
   input  wire  [63:0]            req_dest_operand,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output logic [63:0]            rsp_result,
   output logic                   rsp_carry_flag,
   output logic                   rsp_parity_flag,
   output logic                   rsp_zero_flag,
   output logic                   rsp_sign_flag,
   output logic                   rsp_overflow_flag,
   output logic                   rsp_divide_error
);
   import xalu_pkg::*;

   action_type             act_ff;
   size_type               size_ff;
   logic [63:0]            src_ff, dest_ff;
   logic signed [65:0]     prod_ff;
   logic [63:0]            rem_ff, quo_ff;
   logic [CountWidth-1:0]  cnt_ff;
   flags_type              flags_ff;
   logic                   valid_ff;
   logic [63:0]            res_ff;
   flags_type              oflags_ff;
   logic                   err_ff;

   logic [63:0]            mask, mask2, topm, sm, dm, sdm, r, t, ssm;
   logic [64:0]            rem_sh;
   logic [64:0]            rem_diff;
   logic [5:0]             nval, cidx;
   logic [4:0]             cnt5;
   logic                   is_imul, err;
   logic signed [32:0]     mul_a, mul_b;
   logic signed [65:0]     prod;
   flags_type              nf;

   function automatic logic [63:0] sext(input logic [63:0] v, input size_type sz);
      logic [63:0] o;
      case (sz)
         SIZE_8:  o = {{56{v[7]}}, v[7:0]};
         SIZE_16: o = {{48{v[15]}}, v[15:0]};
         default: o = {{32{v[31]}}, v[31:0]};
      endcase
      return o;
   endfunction

   assign status.div_run  = ((act_ff == ACT_DIV) || (act_ff == ACT_MOD)) && (src_ff != '0);
   assign status.div_last = (cnt_ff == CountWidth'(DivSteps - 1));
   assign status.out_free = !valid_ff || !rsp_stall;

   assign rem_sh   = {rem_ff, quo_ff[63]};
   assign rem_diff = rem_sh - {1'b0, src_ff};

   always_comb begin
      case (size_ff)
         SIZE_8:  begin mask = 64'hFF;        mask2 = 64'hFFFF;      nval = 6'd8;  end
         SIZE_16: begin mask = 64'hFFFF;      mask2 = 64'hFFFF_FFFF; nval = 6'd16; end
         default: begin mask = 64'hFFFF_FFFF; mask2 = '1;            nval = 6'd32; end
      endcase
      topm = mask ^ (mask >> 1);
      sm = src_ff & mask;
      dm = dest_ff & mask;
      sdm = sext(dm, size_ff);
      ssm = sext(sm, size_ff);
      is_imul = (act_ff == ACT_IMUL);
      mul_a = is_imul ? $signed(ssm[32:0]) : $signed({1'b0, sm[31:0]});
      mul_b = is_imul ? $signed(sdm[32:0]) : $signed({1'b0, dm[31:0]});
      prod = mul_a * mul_b;
      cnt5 = sm[4:0];
      cidx = 6'(cnt5) - 6'd1;
      nf = flags_ff;
      r = '0;
      t = '0;
      err = 1'b0;
      case (act_ff)
         ACT_ADD, ACT_ADC: begin
            t = sm + dm + ((act_ff == ACT_ADC) ? 64'(flags_ff.c) : 64'd0);
            r = t & mask;
            nf.c = t[nval];
            nf.o = ((~(sm ^ dm)) & (sm ^ r) & topm) != '0;
         end
         ACT_SUB, ACT_SBB: begin
            t = sm + ((act_ff == ACT_SBB) ? 64'(flags_ff.c) : 64'd0);
            r = (dm - t) & mask;
            nf.c = dm < t;
            nf.o = ((sm ^ dm) & (dm ^ r) & topm) != '0;
         end
         ACT_MUL: begin
            r = prod_ff[63:0];
            nf.c = (r & ~mask) != '0;
            nf.o = nf.c;
         end
         ACT_IMUL: begin
            nf.c = sext(prod_ff[63:0] & mask, size_ff) != prod_ff[63:0];
            nf.o = nf.c;
            r = prod_ff[63:0] & mask2;
         end
         ACT_DIV, ACT_MOD: begin
            if (src_ff == '0) begin
               err = 1'b1;
            end else begin
               r = ((act_ff == ACT_DIV) ? quo_ff : rem_ff) & mask;
            end
         end
         ACT_AND, ACT_XOR, ACT_OR: begin
            r = (act_ff == ACT_AND) ? (dm & sm) : (act_ff == ACT_XOR) ? (dm ^ sm) : (dm | sm);
            nf.c = 1'b0;
            nf.o = 1'b0;
         end
         ACT_SHL, ACT_SAL: begin
            if (cnt5 == '0) begin
               r = dm;
            end else begin
               r = (dm << cnt5) & mask;
               nf.c = (6'(cnt5) <= nval) ? dm[nval - 6'(cnt5)] : 1'b0;
               nf.o = ((r & topm) != '0) ^ nf.c;
            end
         end
         ACT_SHR: begin
            if (cnt5 == '0) begin
               r = dm;
            end else begin
               r = dm >> cnt5;
               nf.c = dm[cidx];
               nf.o = (dm & topm) != '0;
            end
         end
         ACT_SAR: begin
            if (cnt5 == '0) begin
               r = dm;
            end else begin
               r = 64'($signed(sdm) >>> cnt5) & mask;
               nf.c = sdm[cidx];
               nf.o = 1'b0;
            end
         end
         default: r = '0;
      endcase
      case (act_ff)
         ACT_ADD, ACT_ADC, ACT_SUB, ACT_SBB, ACT_AND, ACT_XOR, ACT_OR: begin
            nf.z = (r & mask) == '0;
            nf.s = (r & topm) != '0;
            nf.p = ~^r[7:0];
         end
         ACT_SHL, ACT_SAL, ACT_SHR, ACT_SAR: begin
            if (cnt5 != '0) begin
               nf.z = (r & mask) == '0;
               nf.s = (r & topm) != '0;
               nf.p = ~^r[7:0];
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load_op) begin
         act_ff  <= action_type'(req_action);
         size_ff <= size_type'(req_size_sel);
         src_ff  <= req_src_operand;
         dest_ff <= req_dest_operand;
      end
      prod_ff <= prod;
      if (cmd.div_init) begin
         rem_ff <= '0;
         quo_ff <= dest_ff;
      end else if (cmd.div_step) begin
         if (!rem_diff[64]) begin
            rem_ff <= rem_diff[63:0];
            quo_ff <= {quo_ff[62:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[63:0];
            quo_ff <= {quo_ff[62:0], 1'b0};
         end
      end
      if (cmd.load_out) begin
         res_ff    <= r;
         oflags_ff <= nf;
         err_ff    <= err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         if (cmd.div_init) begin
            cnt_ff <= '0;
         end else if (cmd.div_step) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (cmd.load_out) begin
            flags_ff <= nf;
            valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_result        = res_ff;
   assign rsp_carry_flag    = oflags_ff.c;
   assign rsp_parity_flag   = oflags_ff.p;
   assign rsp_zero_flag     = oflags_ff.z;
   assign rsp_sign_flag     = oflags_ff.s;
   assign rsp_overflow_flag = oflags_ff.o;
   assign rsp_divide_error  = err_ff;

endmodule
`default_nettype wire

/* rtl/x86_integer_alu_with_flags_unit.sv */
`default_nettype none
// Each accepted word passes through the controller states START and FIN before its
// result is registered; a nonzero-divisor div or mod also runs 64 restoring divide
// steps in DIV. A new word is accepted only in IDLE, after the last result is loaded,
// as the single shared datapath and the one-bit-per-cycle divider serve one word.
// Synchronous reset clears the controller, output valid, step counter and flags_ff.
module x86_integer_alu_with_flags_unit (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_valid,
   output logic         req_stall,
   input  wire  [3:0]   req_action,
   input  wire  [1:0]   req_size_sel,
   input  wire  [63:0]  req_src_operand,
   input  wire  [63:0]  req_dest_operand,
   output logic         rsp_valid,
   input  wire          rsp_stall,
   output logic [63:0]  rsp_result,
   output logic         rsp_carry_flag,
   output logic         rsp_parity_flag,
   output logic         rsp_zero_flag,
   output logic         rsp_sign_flag,
   output logic         rsp_overflow_flag,
   output logic         rsp_divide_error
);
   import xalu_pkg::*;

   cmd_type    cmd;
   status_type status;

   xalu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   xalu_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_action        (req_action),
      .req_size_sel      (req_size_sel),
      .req_src_operand   (req_src_operand),
      .req_dest_operand  (req_dest_operand),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result        (rsp_result),
      .rsp_carry_flag    (rsp_carry_flag),
      .rsp_parity_flag   (rsp_parity_flag),
      .rsp_zero_flag     (rsp_zero_flag),
      .rsp_sign_flag     (rsp_sign_flag),
      .rsp_overflow_flag (rsp_overflow_flag),
      .rsp_divide_error  (rsp_divide_error)
   );

endmodule
`default_nettype wire

/* tb/sv/tb_x86_integer_alu_with_flags_unit.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb_x86_integer_alu_with_flags_unit;
   import xalu_pkg::*;

   typedef struct {
      logic [63:0] result;
      logic c, p, z, s, o, err;
   } alu_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [3:0] req_action = '0;
   logic [1:0] req_size_sel = '0;
   logic [63:0] req_src_operand = '0;
   logic [63:0] req_dest_operand = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [63:0] rsp_result;
   logic rsp_carry_flag, rsp_parity_flag, rsp_zero_flag;
   logic rsp_sign_flag, rsp_overflow_flag, rsp_divide_error;

   flags_type model_flags;
   alu_word_type expected_words[$];
   int fail_count = 0;
   bit send_idle_en = 1'b0;
   bit recv_idle_en = 1'b0;
   int hold_off_cycles = 0;

   x86_integer_alu_with_flags_unit i_dut (.*);

   always #5 clock = ~clock;

   function automatic logic [63:0] sign_extend(logic [63:0] v, int n);
      logic [63:0] m;
      m = (64'd1 << n) - 1;
      v = v & m;
      if (v[n-1]) v = v | ~m;
      return v;
   endfunction

   function automatic void update_szp(logic [63:0] r, int n);
      model_flags.z = ((r & ((64'd1 << n) - 1)) == 0);
      model_flags.s = r[n-1];
      model_flags.p = ~^r[7:0];
   endfunction

   function automatic alu_word_type compute_alu(logic [3:0] act, logic [1:0] sel,
                                                logic [63:0] s, logic [63:0] d);
      alu_word_type w;
      int n;
      int cnt;
      logic [63:0] m, top, sm, dm, r, t, b, p, sx;
      n = (sel == SIZE_8) ? 8 : (sel == SIZE_16) ? 16 : 32;
      m = (64'd1 << n) - 1;
      top = 64'd1 << (n - 1);
      sm = s & m;
      dm = d & m;
      r = '0;
      w.err = 1'b0;
      cnt = int'(sm[4:0]);
      case (action_type'(act))
         ACT_ADD, ACT_ADC: begin
            t = sm + dm + ((act == ACT_ADC) ? 64'(model_flags.c) : 64'd0);
            r = t & m;
            model_flags.c = t[n];
            model_flags.o = ((~(sm ^ dm)) & (sm ^ r) & top) != 0;
            update_szp(r, n);
         end
         ACT_SUB, ACT_SBB: begin
            b = (act == ACT_SBB) ? 64'(model_flags.c) : 64'd0;
            r = (dm - sm - b) & m;
            model_flags.c = dm < sm + b;
            model_flags.o = ((sm ^ dm) & (dm ^ r) & top) != 0;
            update_szp(r, n);
         end
         ACT_MUL: begin
            r = sm * dm;
            model_flags.c = (r >> n) != 0;
            model_flags.o = model_flags.c;
         end
         ACT_IMUL: begin
            p = sign_extend(sm, n) * sign_extend(dm, n);
            model_flags.c = sign_extend(p & m, n) != p;
            model_flags.o = model_flags.c;
            r = (n == 32) ? p : (p & ((64'd1 << (2 * n)) - 1));
         end
         ACT_DIV, ACT_MOD: begin
            if (s == 0) w.err = 1'b1;
            else r = ((act == ACT_DIV) ? d / s : d % s) & m;
         end
         ACT_AND, ACT_XOR, ACT_OR: begin
            r = (act == ACT_AND) ? (dm & sm) : (act == ACT_XOR) ? (dm ^ sm) : (dm | sm);
            model_flags.c = 1'b0;
            model_flags.o = 1'b0;
            update_szp(r, n);
         end
         ACT_SHL, ACT_SAL: begin
            if (cnt == 0) r = dm;
            else begin
               r = (dm << cnt) & m;
               model_flags.c = (cnt <= n) ? dm[n-cnt] : 1'b0;
               model_flags.o = r[n-1] ^ model_flags.c;
               update_szp(r, n);
            end
         end
         ACT_SHR: begin
            if (cnt == 0) r = dm;
            else begin
               r = dm >> cnt;
               model_flags.c = dm[cnt-1];
               model_flags.o = dm[n-1];
               update_szp(r, n);
            end
         end
         ACT_SAR: begin
            if (cnt == 0) r = dm;
            else begin
               sx = sign_extend(dm, n);
               r = 64'($signed(sx) >>> cnt) & m;
               model_flags.c = sx[cnt-1];
               model_flags.o = 1'b0;
               update_szp(r, n);
            end
         end
         default: r = '0;
      endcase
      w.result = r;
      w.c = model_flags.c;
      w.p = model_flags.p;
      w.z = model_flags.z;
      w.s = model_flags.s;
      w.o = model_flags.o;
      return w;
   endfunction

   task automatic send_word(logic [3:0] act, logic [1:0] sel, logic [63:0] s,
                            logic [63:0] d);
      int gap;
      if (send_idle_en && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 19);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_size_sel <= sel;
      req_src_operand <= s;
      req_dest_operand <= d;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_words.push_back(compute_alu(act, sel, s, d));
      @(negedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [63:0] edge_value();
      case ($urandom_range(0, 7))
         0: return 64'd0;
         1: return 64'd1;
         2: return 64'h7f;
         3: return 64'h80;
         4: return 64'hffff;
         5: return 64'h8000_0000;
         6: return '1;
         default: return rand64();
      endcase
   endfunction

   // Reception and comparison of each result word, with random stalling.
   always @(posedge clock) begin
      alu_word_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            $error("result word with none expected");
            fail_count++;
         end else begin
            e = expected_words.pop_front();
            if (rsp_result !== e.result) begin
               $error("result exp %h got %h", e.result, rsp_result); fail_count++;
            end
            if (rsp_carry_flag !== e.c) begin
               $error("carry_flag exp %b got %b", e.c, rsp_carry_flag); fail_count++;
            end
            if (rsp_parity_flag !== e.p) begin
               $error("parity_flag exp %b got %b", e.p, rsp_parity_flag); fail_count++;
            end
            if (rsp_zero_flag !== e.z) begin
               $error("zero_flag exp %b got %b", e.z, rsp_zero_flag); fail_count++;
            end
            if (rsp_sign_flag !== e.s) begin
               $error("sign_flag exp %b got %b", e.s, rsp_sign_flag); fail_count++;
            end
            if (rsp_overflow_flag !== e.o) begin
               $error("overflow_flag exp %b got %b", e.o, rsp_overflow_flag);
               fail_count++;
            end
            if (rsp_divide_error !== e.err) begin
               $error("divide_error exp %b got %b", e.err, rsp_divide_error);
               fail_count++;
            end
         end
      end
   end

   initial begin
      int burst;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_off_cycles--;
         end else if (recv_idle_en && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 19);
            rsp_stall <= 1'b1;
            repeat (burst - 1) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic test_directed();
      for (int a = 0; a < 16; a++)
         send_word(4'(a), SIZE_32, 64'h3, 64'hffff_ffff);
      send_word(ACT_DIV, SIZE_8, 64'd0, 64'd100);
      send_word(ACT_MOD, SIZE_16, 64'd0, '1);
      send_word(ACT_DIV, SIZE_32X, 64'd1, '1);
      send_word(ACT_SHL, SIZE_8, 64'd0, 64'h81);
      send_word(ACT_SAR, SIZE_8, 64'd31, 64'h80);
      send_word(ACT_SHL, SIZE_16, 64'd17, 64'hffff);
      send_word(ACT_IMUL, SIZE_32, 64'h8000_0000, 64'h8000_0000);
      send_word(ACT_ADC, SIZE_8, '1, '1);
      send_word(ACT_SBB, SIZE_16, '1, 64'd0);
   endtask

   task automatic test_random(int count);
      logic [3:0] act;
      logic [63:0] s;
      for (int i = 0; i < count; i++) begin
         act = 4'($urandom_range(0, 15));
         s = $urandom_range(0, 1) ? edge_value() : rand64();
         if ((act == ACT_DIV || act == ACT_MOD) && $urandom_range(0, 3) != 0)
            s = 64'($urandom_range(1, 1000));
         if (act >= ACT_SHL && act <= ACT_SAL && $urandom_range(0, 1))
            s = 64'($urandom_range(0, 40));
         send_word(act, 2'($urandom_range(0, 3)), s,
                   $urandom_range(0, 1) ? edge_value() : rand64());
      end
   endtask

   task automatic test_backpressure();
      hold_off_cycles = 300;
      for (int i = 0; i < 10; i++)
         send_word(ACT_ADD, SIZE_32, rand64(), rand64());
   endtask

   initial begin
      model_flags = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      send_idle_en = 1'b1;
      recv_idle_en = 1'b1;
      test_random(1000);
      test_backpressure();
      test_random(300);
      send_idle_en = 1'b0;
      recv_idle_en = 1'b0;
      test_random(230);
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0 && expected_words.size() == 0)
         $display("x86_integer_alu_with_flags_unit verification clean");
      else
         $display("x86_integer_alu_with_flags_unit verification failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("x86_integer_alu_with_flags_unit verification failed");
      $finish;
   end

endmodule
`default_nettype wire
